[src/ftr_pkg.sv]
// ----------------------------------------------------------------------------
// ftr_pkg
// Shared types and constants for the feature tag remap table.
// ----------------------------------------------------------------------------
package ftr_pkg;

  localparam int unsigned TAG_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned OP_W  = 3;

  // in_tdata: operation, entry_old_tag, entry_old_value, entry_new_tag,
  // entry_new_value, query_tag, query_value; 195 bits used, padded to 200
  localparam int unsigned IN_W  = 200;
  // out_tdata: result_tag, result_value, status; 65 bits used, padded to 72
  localparam int unsigned OUT_W = 72;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR    = 3'd0,
    OP_APPEND   = 3'd1,
    OP_UP_TAG   = 3'd2,
    OP_DOWN_TAG = 3'd3,
    OP_UP_VAL   = 3'd4,
    OP_DOWN_VAL = 3'd5
  } ftr_op_t;

  typedef struct packed {
    logic [TAG_W-1:0] old_tag;
    logic [VAL_W-1:0] old_val;
    logic [TAG_W-1:0] new_tag;
    logic [VAL_W-1:0] new_val;
  } ftr_entry_t;

endpackage

[src/ftr_entry_ram.sv]
// ----------------------------------------------------------------------------
// ftr_entry_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ftr_entry_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  ftr_pkg::ftr_entry_t wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output ftr_pkg::ftr_entry_t rd_data
);
  import ftr_pkg::*;

  ftr_entry_t mem [DEPTH];
  ftr_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/feature_tag_remap_table_unit.sv]
// ----------------------------------------------------------------------------
// feature_tag_remap_table_unit
// Remap table: clear, append, and tag / tag+value remaps in either direction.
// ----------------------------------------------------------------------------
//  channel | ports                         | payload
//  --------+-------------------------------+----------------------------------
//  input   | in_tvalid/in_tready/in_tdata  | op, entry (old, new), query
//  result  | out_tvalid/out_tready/out_tdata | result tag, value, status
//
//  Clear and append: straight from acceptance to the output register.
//  Remaps: one pass over the table, one entry a cycle through the single RAM
//  read port, over the count entries held (at most TABLE_DEPTH).
//  One item at a time; in_tready is low from acceptance until the result is
//  taken. out_tready may stall indefinitely; the result holds.
//  Synchronous active-low reset empties the table (count to zero).
// ----------------------------------------------------------------------------
module feature_tag_remap_table_unit #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // [2:0] operation, [34:3] entry_old_tag, [66:35] entry_old_value,
  // [98:67] entry_new_tag, [130:99] entry_new_value, [162:131] query_tag,
  // [194:163] query_value, [199:195] zero
  input  logic [ftr_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [31:0] result_tag, [63:32] result_value, [64] status, [71:65] zero
  output logic [ftr_pkg::OUT_W-1:0]  out_tdata
);
  import ftr_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

  state_t state_r;

  logic [OP_W-1:0]  in_op;
  ftr_entry_t       in_entry;
  logic [TAG_W-1:0] in_qtag;
  logic [VAL_W-1:0] in_qval;

  assign in_op    = in_tdata[2:0];
  assign in_entry = '{old_tag: in_tdata[34:3],   old_val: in_tdata[66:35],
                      new_tag: in_tdata[98:67],  new_val: in_tdata[130:99]};
  assign in_qtag  = in_tdata[162:131];
  assign in_qval  = in_tdata[194:163];

  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    idx_r;
  logic             rd_pend_r;
  logic             down_r;
  logic             is_val_r;
  logic [TAG_W-1:0] q_tag_r;
  logic [VAL_W-1:0] q_val_r;

  // scan flags
  logic             found_r;
  logic             oth_seen_r;
  logic [TAG_W-1:0] f_oth_tag_r;
  logic [VAL_W-1:0] f_key_val_r;
  logic             ex_found_r;
  logic [TAG_W-1:0] ex_tag_r;
  logic [VAL_W-1:0] ex_val_r;
  logic             rev_r;

  logic [TAG_W-1:0] res_tag_r;
  logic [VAL_W-1:0] res_val_r;
  logic             res_st_r;

  logic       in_acc;
  logic       full;
  logic       wr_en;
  logic       rd_en;
  logic       scan_end;
  ftr_entry_t rd_entry;

  assign in_acc   = in_tvalid && in_tready;
  assign full     = (cnt_r == FULL_CNT);
  assign wr_en    = in_acc && (in_op == OP_APPEND) && !full;
  assign rd_en    = (state_r == ST_SCAN) && (idx_r < cnt_r);
  assign scan_end = (state_r == ST_SCAN) && !(idx_r < cnt_r) && !rd_pend_r;

  ftr_entry_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (in_entry),
    .rd_en   (rd_en),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_entry)
  );

  // compare unit: key side is old for upgrades, new for downgrades
  logic [TAG_W-1:0] key_tag, oth_tag;
  logic [VAL_W-1:0] key_val, oth_val;
  logic             key_hit, oth_hit;

  always_comb begin
    key_tag = down_r ? rd_entry.new_tag : rd_entry.old_tag;
    key_val = down_r ? rd_entry.new_val : rd_entry.old_val;
    oth_tag = down_r ? rd_entry.old_tag : rd_entry.new_tag;
    oth_val = down_r ? rd_entry.old_val : rd_entry.new_val;
    key_hit = (key_tag == q_tag_r);
    oth_hit = (oth_tag == q_tag_r);
  end

  // final decision once the pass is over
  logic [TAG_W-1:0] fin_tag;
  logic [VAL_W-1:0] fin_val;

  always_comb begin
    if (!found_r) begin
      fin_tag = oth_seen_r ? '0 : q_tag_r;
      fin_val = (oth_seen_r || !is_val_r) ? '0 : q_val_r;
    end else if (!is_val_r) begin
      fin_tag = f_oth_tag_r;
      fin_val = '0;
    end else if ((f_key_val_r != '0) && ex_found_r) begin
      fin_tag = ex_tag_r;
      fin_val = (ex_tag_r == '0) ? '0 : ex_val_r;
    end else if ((f_key_val_r != '0) && rev_r) begin
      fin_tag = '0;
      fin_val = '0;
    end else begin
      fin_tag = f_oth_tag_r;
      fin_val = q_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      idx_r     <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            res_tag_r   <= '0;
            res_val_r   <= '0;
            res_st_r    <= 1'b0;
            q_tag_r     <= in_qtag;
            q_val_r     <= in_qval;
            down_r      <= (in_op == OP_DOWN_TAG) || (in_op == OP_DOWN_VAL);
            is_val_r    <= (in_op == OP_UP_VAL) || (in_op == OP_DOWN_VAL);
            idx_r       <= '0;
            rd_pend_r   <= 1'b0;
            found_r     <= 1'b0;
            oth_seen_r  <= 1'b0;
            ex_found_r  <= 1'b0;
            rev_r       <= 1'b0;
            case (in_op)
              OP_CLEAR: begin
                cnt_r   <= '0;
                state_r <= ST_DONE;
              end
              OP_APPEND: begin
                if (full) begin
                  res_st_r <= 1'b1;
                end else begin
                  cnt_r <= cnt_r + 1'b1;
                end
                state_r <= ST_DONE;
              end
              OP_UP_TAG, OP_DOWN_TAG, OP_UP_VAL, OP_DOWN_VAL: begin
                state_r <= ST_SCAN;
              end
              default: begin
                state_r <= ST_DONE;
              end
            endcase
          end
        end
        ST_SCAN: begin
          rd_pend_r <= rd_en;
          if (rd_en) begin
            idx_r <= idx_r + 1'b1;
          end
          if (rd_pend_r) begin
            if (key_hit && !found_r) begin
              found_r     <= 1'b1;
              f_oth_tag_r <= oth_tag;
              f_key_val_r <= key_val;
            end
            if (oth_hit) begin
              oth_seen_r <= 1'b1;
            end
            if (key_hit && (key_val == q_val_r) && !ex_found_r) begin
              ex_found_r <= 1'b1;
              ex_tag_r   <= oth_tag;
              ex_val_r   <= oth_val;
            end
            if (key_hit && (oth_val == q_val_r)) begin
              rev_r <= 1'b1;
            end
          end
          if (scan_end) begin
            res_tag_r <= fin_tag;
            res_val_r <= fin_val;
            res_st_r  <= 1'b0;
            state_r   <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_tready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_DONE);
  assign out_tdata  = {7'd0, res_st_r, res_val_r, res_tag_r};

  // ---- checks ----
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("entry count beyond table depth");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (idx_r <= cnt_r))
    else $error("scan index ran past entry count");

  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_op == OP_APPEND) && full) |=> (res_st_r && $stable(cnt_r)))
    else $error("append to full table not refused");

  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |=> $stable(cnt_r))
    else $error("table count changed during a scan");

endmodule
